>>> rtl/shs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_pkg: shared types and constants of the sensorless homing sequencer
// Field widths, register indexes, the homing phase codes and the register
// bundle that the top level hands to the step logic.
// ----------------------------------------------------------------------------
package shs_pkg;

  // Default values of the top-level parameters.
  localparam int DEBOUNCE_WIDTH_DEF = 16;
  localparam int VELOCITY_WIDTH_DEF = 24;

  // Fixed field and register widths.
  localparam int LOAD_W     = 10;
  localparam int STALL_W    = 10;
  localparam int SPEED_W    = 23;
  localparam int DEBCFG_W   = 16;
  localparam int PHASE_W    = 3;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STALL_THRESHOLD  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_DEBOUNCE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKING_DEBOUNCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_DEBOUNCE   = 3'd4;

  typedef enum logic [PHASE_W-1:0] {
    PH_UNKNOWN   = 3'd0,
    PH_SEARCHING = 3'd1,
    PH_BACKING   = 3'd2,
    PH_LATCHING  = 3'd3,
    PH_HOMED     = 3'd4
  } phase_t;

  typedef struct packed {
    logic [STALL_W-1:0]  stall_threshold;
    logic [SPEED_W-1:0]  speed_threshold;
    logic [DEBCFG_W-1:0] search_debounce;
    logic [DEBCFG_W-1:0] backing_debounce;
    logic [DEBCFG_W-1:0] latch_debounce;
  } cfg_regs_t;

  typedef struct packed {
    phase_t phase;
    logic   switch_on;
  } homing_state_t;

endpackage

>>> rtl/shs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_if: valid/ready channels of the sensorless homing sequencer
// One interface for the tick word going in and one for the result word.
// ----------------------------------------------------------------------------
interface shs_in_if import shs_pkg::*; #(
  parameter int VELOCITY_WIDTH = VELOCITY_WIDTH_DEF
);
  logic                             valid;
  logic                             ready;
  logic                             homing_request;
  logic        [LOAD_W-1:0]         motor_load;
  logic signed [VELOCITY_WIDTH-1:0] velocity;

  modport source (output valid, homing_request, motor_load, velocity, input ready);
  modport sink   (input valid, homing_request, motor_load, velocity, output ready);
endinterface

interface shs_out_if import shs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               home_switch;
  logic [PHASE_W-1:0] homing_phase;

  modport source (output valid, home_switch, homing_phase, input ready);
  modport sink   (input valid, home_switch, homing_phase, output ready);
endinterface

>>> rtl/shs_phase_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shs_phase_step: next-state logic of the homing phase machine
// Stall and motion detection for one tick word, the debounce counter with
// saturation, and the phase advance.
// ----------------------------------------------------------------------------
module shs_phase_step import shs_pkg::*; #(
  parameter int DEBOUNCE_WIDTH = DEBOUNCE_WIDTH_DEF,
  parameter int VELOCITY_WIDTH = VELOCITY_WIDTH_DEF
) (
  input  cfg_regs_t                        cfg,
  input  logic                             homing_request,
  input  logic        [LOAD_W-1:0]         motor_load,
  input  logic signed [VELOCITY_WIDTH-1:0] velocity,
  input  homing_state_t                    cur_state,
  input  logic        [DEBOUNCE_WIDTH-1:0] cur_count,
  output homing_state_t                    nxt_state,
  output logic        [DEBOUNCE_WIDTH-1:0] nxt_count
);

  localparam int MAG_CMP_W = (VELOCITY_WIDTH > SPEED_W) ? VELOCITY_WIDTH : SPEED_W;
  localparam int LIM_CMP_W = (DEBOUNCE_WIDTH > DEBCFG_W) ? DEBOUNCE_WIDTH : DEBCFG_W;

  logic [VELOCITY_WIDTH-1:0] magnitude;
  logic                      moving;
  logic                      stalled;
  logic                      fast;
  logic                      stall_hit;
  phase_t                    entry_phase;
  logic                      qualify;
  logic [DEBCFG_W-1:0]       limit;
  phase_t                    target_phase;
  logic                      target_switch;

  // Two's complement negate in the field width gives the exact magnitude,
  // the most negative value included, when read as unsigned.
  assign magnitude = velocity[VELOCITY_WIDTH-1] ? (~velocity + 1'b1) : velocity;
  assign moving    = |velocity;
  assign stalled   = motor_load <= cfg.stall_threshold;
  assign fast      = MAG_CMP_W'(magnitude) > MAG_CMP_W'(cfg.speed_threshold);
  assign stall_hit = !cur_state.switch_on && stalled && fast && moving;

  assign entry_phase = (cur_state.phase == PH_UNKNOWN) ? PH_SEARCHING : cur_state.phase;

  always_comb begin
    qualify       = 1'b0;
    limit         = cfg.search_debounce;
    target_phase  = PH_BACKING;
    target_switch = 1'b1;
    unique case (entry_phase)
      PH_SEARCHING: begin
        qualify = stall_hit;
      end
      PH_BACKING: begin
        qualify       = moving;
        limit         = cfg.backing_debounce;
        target_phase  = PH_LATCHING;
        target_switch = 1'b0;
      end
      PH_LATCHING: begin
        qualify      = stall_hit;
        limit        = cfg.latch_debounce;
        target_phase = PH_HOMED;
      end
      default: begin
        qualify = 1'b0;
      end
    endcase
  end

  always_comb begin
    nxt_state.phase     = entry_phase;
    nxt_state.switch_on = cur_state.switch_on;
    nxt_count           = '0;
    if (!homing_request) begin
      nxt_state.phase     = PH_UNKNOWN;
      nxt_state.switch_on = 1'b0;
    end else if (qualify) begin
      if (LIM_CMP_W'(cur_count) > LIM_CMP_W'(limit)) begin
        nxt_state.phase     = target_phase;
        nxt_state.switch_on = target_switch;
      end else if (cur_count != '1) begin
        nxt_count = cur_count + 1'b1;
      end else begin
        nxt_count = cur_count;
      end
    end
  end

endmodule

>>> rtl/sensorless_homing_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensorless_homing_sequencer: virtual home switch from stall detection
// Steps the homing phase machine once per servo tick word and returns the
// switch level and phase after each tick.
// ----------------------------------------------------------------------------
// The block takes one tick word per clock while the output is not stalled
// and returns one result word for each: the word is first captured in an
// input register, then the phase, switch and debounce counter are updated
// in a single step in the state register and the new phase and switch
// level become the result. That single-step state update is what
// sets the rate of one word per clock. An idle result slot or a taken result
// lets the input register move on, so a new word is accepted while a finished
// result still waits, and a stalled output backs up only after the input
// register fills. Configuration registers are written through the cfg_ port
// at any edge with cfg_we high; writes to indexes past the register list are
// ignored. Config registers, valid flags and phase state reset to zero.
// ----------------------------------------------------------------------------
module sensorless_homing_sequencer import shs_pkg::*; #(
  parameter int DEBOUNCE_WIDTH = DEBOUNCE_WIDTH_DEF,
  parameter int VELOCITY_WIDTH = VELOCITY_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  shs_in_if.sink                in_ch,
  shs_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  cfg_regs_t cfg_r;

  // Input register stage.
  logic                             s1_valid_r;
  logic                             s1_request_r;
  logic        [LOAD_W-1:0]         s1_load_r;
  logic signed [VELOCITY_WIDTH-1:0] s1_velocity_r;

  // Phase state; it doubles as the result payload.
  homing_state_t             state_r;
  homing_state_t             state_nxt;
  logic [DEBOUNCE_WIDTH-1:0] count_r;
  logic [DEBOUNCE_WIDTH-1:0] count_nxt;
  logic                      out_valid_r;

  logic advance;

  // The input register hands its word on when the result slot is free or is
  // being emptied in this cycle.
  assign advance      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || advance;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.home_switch  = state_r.switch_on;
  assign out_ch.homing_phase = state_r.phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STALL_THRESHOLD:  cfg_r.stall_threshold  <= cfg_data[STALL_W-1:0];
        REG_SPEED_THRESHOLD:  cfg_r.speed_threshold  <= cfg_data[SPEED_W-1:0];
        REG_SEARCH_DEBOUNCE:  cfg_r.search_debounce  <= cfg_data[DEBCFG_W-1:0];
        REG_BACKING_DEBOUNCE: cfg_r.backing_debounce <= cfg_data[DEBCFG_W-1:0];
        REG_LATCH_DEBOUNCE:   cfg_r.latch_debounce   <= cfg_data[DEBCFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage control; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_request_r  <= in_ch.homing_request;
      s1_load_r     <= in_ch.motor_load;
      s1_velocity_r <= in_ch.velocity;
    end
  end

  shs_phase_step #(
    .DEBOUNCE_WIDTH (DEBOUNCE_WIDTH),
    .VELOCITY_WIDTH (VELOCITY_WIDTH)
  ) u_step (
    .cfg            (cfg_r),
    .homing_request (s1_request_r),
    .motor_load     (s1_load_r),
    .velocity       (s1_velocity_r),
    .cur_state      (state_r),
    .cur_count      (count_r),
    .nxt_state      (state_nxt),
    .nxt_count      (count_nxt)
  );

  // The phase state moves only when a word leaves the input register, so the
  // result on the output always matches the last word stepped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase     <= PH_UNKNOWN;
      state_r.switch_on <= 1'b0;
      count_r           <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (advance) begin
        state_r     <= state_nxt;
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The switch is on exactly in the backing and homed phases.
  a_switch_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.switch_on == (state_r.phase == PH_BACKING || state_r.phase == PH_HOMED))
    else $error("home switch level disagrees with homing phase");

  // A result that waits keeps its phase and switch level.
  a_state_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(state_r))
    else $error("homing state changed while a result word was stalled");

  // The phase only steps forward by one or drops back to unknown.
  a_phase_single_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (state_r.phase != $past(state_r.phase)) |->
      (state_r.phase == PH_UNKNOWN) ||
      (state_r.phase == PHASE_W'($past(state_r.phase) + 3'd1)))
    else $error("homing phase skipped a step");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sensorless homing sequencer
// Drives tick words through the valid/ready input channel, predicts the
// switch level and homing phase of every tick with a cycle-free model of the
// phase machine, and compares each result word against it in order. The run
// covers a directed walk through every phase, six register settings, some
// randomized, under changing back-pressure, and a closing stall run with
// the debounce registers at 65534.
// ----------------------------------------------------------------------------
module tb;
  import shs_pkg::*;

  localparam int VW = VELOCITY_WIDTH_DEF;
  localparam int DW = DEBOUNCE_WIDTH_DEF;
  localparam logic signed [VW-1:0] VEL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VEL_MIN = {1'b1, {(VW-1){1'b0}}};
  localparam logic [LOAD_W-1:0] LOAD_MAX = '1;
  localparam int DEB_MAX = 65534;
  // Stalled ticks in the closing run; far too few to reach the largest limit.
  localparam int LONG_RUN = 16;

  // --------------------------------------------------------------------------
  // Phase tracker: holds its own copy of the registers and the phase state,
  // and keeps one expected result word per accepted tick word.
  // --------------------------------------------------------------------------
  class homing_tracker;
    cfg_regs_t       regs;
    phase_t          phase;
    logic            switch_on;
    logic [DW-1:0]   count;
    homing_state_t   expected_q[$];
    int              mismatches;
    int              results;
    int              homed_hits;

    function new();
      regs       = '0;
      phase      = PH_UNKNOWN;
      switch_on  = 1'b0;
      count      = '0;
      mismatches = 0;
      results    = 0;
      homed_hits = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_STALL_THRESHOLD:  regs.stall_threshold  = val[STALL_W-1:0];
        REG_SPEED_THRESHOLD:  regs.speed_threshold  = val[SPEED_W-1:0];
        REG_SEARCH_DEBOUNCE:  regs.search_debounce  = val[DEBCFG_W-1:0];
        REG_BACKING_DEBOUNCE: regs.backing_debounce = val[DEBCFG_W-1:0];
        REG_LATCH_DEBOUNCE:   regs.latch_debounce   = val[DEBCFG_W-1:0];
        default: ;
      endcase
    endfunction

    // The counter must climb past the limit before the phase moves on; it
    // holds at all ones rather than wrapping.
    function void debounce(logic [DEBCFG_W-1:0] limit, phase_t next_phase, logic next_switch);
      if (count > limit) begin
        switch_on = next_switch;
        count     = '0;
        phase     = next_phase;
      end else if (count != '1) begin
        count = count + 1'b1;
      end
    endfunction

    function void note_tick(logic req, logic [LOAD_W-1:0] load, logic signed [VW-1:0] vel);
      logic [VW:0]   magnitude;
      logic          moving;
      logic          stalled;
      logic          fast;
      logic          stall_hit;
      homing_state_t e;
      // One bit wider than the velocity so the most negative value is exact.
      magnitude = vel[VW-1] ? ({1'b0, ~vel} + 1'b1) : {1'b0, vel};
      moving    = (vel != '0);
      stalled   = (load <= regs.stall_threshold);
      fast      = (magnitude > {{(VW+1-SPEED_W){1'b0}}, regs.speed_threshold});
      if (!req) begin
        switch_on = 1'b0;
        count     = '0;
        phase     = PH_UNKNOWN;
      end else begin
        stall_hit = !switch_on && stalled && fast && moving;
        if (phase == PH_UNKNOWN) phase = PH_SEARCHING;
        if (phase == PH_SEARCHING && stall_hit)
          debounce(regs.search_debounce, PH_BACKING, 1'b1);
        else if (phase == PH_BACKING && moving)
          debounce(regs.backing_debounce, PH_LATCHING, 1'b0);
        else if (phase == PH_LATCHING && stall_hit)
          debounce(regs.latch_debounce, PH_HOMED, 1'b1);
        else
          count = '0;
      end
      e.phase     = phase;
      e.switch_on = switch_on;
      expected_q.push_back(e);
    endfunction

    function void check_result(logic sw, logic [PHASE_W-1:0] ph);
      homing_state_t e;
      if (expected_q.size() == 0) begin
        $error("result word with no tick word outstanding: switch %0d phase %0d", sw, ph);
        mismatches++;
      end else begin
        e = expected_q.pop_front();
        results++;
        if (ph == PH_HOMED) homed_hits++;
        if (sw !== e.switch_on) begin
          $error("home_switch: expected %0d, got %0d", e.switch_on, sw);
          mismatches++;
        end
        if (ph !== e.phase) begin
          $error("homing_phase: expected %0d, got %0d", e.phase, ph);
          mismatches++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block itself.
  // --------------------------------------------------------------------------
  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  shs_in_if #(.VELOCITY_WIDTH(VW)) in_ch ();
  shs_out_if                       out_ch ();

  sensorless_homing_sequencer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  homing_tracker tracker = new();

  int send_idle_pct;
  int recv_idle_pct;
  int ticks_sent;
  int settings;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // The receiver drops ready at random; with the idle percentage at zero it
  // takes a word on every clock.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Both handshakes are sampled at the edge, before any driver update of the
  // same edge lands, so the tick word is noted before its result can arrive.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_tick(in_ch.homing_request, in_ch.motor_load, in_ch.velocity);
      if (out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.home_switch, out_ch.homing_phase);
    end
  end

  // --------------------------------------------------------------------------
  // Drivers.
  // --------------------------------------------------------------------------

  // Offers one tick word and returns at the edge that accepts it. Valid stays
  // high afterwards so back-to-back words go out without a bubble.
  task automatic send_tick(input logic req, input logic [LOAD_W-1:0] load,
                           input logic signed [VW-1:0] vel);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.homing_request <= req;
    in_ch.motor_load     <= load;
    in_ch.velocity       <= vel;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    ticks_sent++;
  endtask

  // A tick that qualifies in searching, backing and latching: stalled load,
  // speed above the threshold and nonzero velocity. A run of these walks the
  // machine all the way to homed.
  task automatic send_stall_tick();
    int                     mag;
    logic signed [VW-1:0]   vel;
    logic [LOAD_W-1:0]      load;
    mag  = $urandom_range(tracker.regs.speed_threshold + 1, 1 << (VW - 1));
    load = LOAD_W'($urandom_range(0, tracker.regs.stall_threshold));
    // Only the negative side reaches a magnitude of full scale.
    if (mag == (1 << (VW - 1)) || $urandom_range(0, 1) == 1)
      vel = VW'(-mag);
    else
      vel = VW'(mag);
    send_tick(1'b1, load, vel);
  endtask

  // Holds valid low until every tick word in flight has produced its result.
  // The first edge lets the monitor note a word accepted just before.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    tracker.set_reg(idx, CFG_DATA_W'(val));
    @(posedge clk);
  endtask

  // Writes all five registers back to back; only called with nothing in flight.
  task automatic program_regs(input int stall, input int speed, input int search_deb,
                              input int backing_deb, input int latch_deb);
    write_reg(REG_STALL_THRESHOLD, stall);
    write_reg(REG_SPEED_THRESHOLD, speed);
    write_reg(REG_SEARCH_DEBOUNCE, search_deb);
    write_reg(REG_BACKING_DEBOUNCE, backing_deb);
    write_reg(REG_LATCH_DEBOUNCE, latch_deb);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Mostly well-formed homing runs: request held over a stretch of stalled
  // ticks with noise that resets the debounce counter, then the request drops.
  // The rest are bursts of fully random words, request bit included, which
  // also break runs off midway.
  task automatic run_random_phase(input int n);
    int stop;
    int len;
    int r;
    int mag;
    logic signed [VW-1:0] vel;
    stop = ticks_sent + n;
    while (ticks_sent < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 8))
          send_tick(1'($urandom), LOAD_W'($urandom), VW'($urandom));
      end else begin
        len = $urandom_range(2, 30);
        repeat (len) begin
          r   = $urandom_range(0, 99);
          vel = VW'($urandom);
          mag = $urandom_range(0, tracker.regs.speed_threshold);
          if (r < 86) begin
            send_stall_tick();
          end else if (r < 96) begin
            // Noise aimed at the stall condition: high load, slow speed, no motion or a random word.
            case ($urandom_range(0, 3))
              0: begin
                if (tracker.regs.stall_threshold != LOAD_MAX)
                  send_tick(1'b1,
                            LOAD_W'($urandom_range(tracker.regs.stall_threshold + 1,
                                                   LOAD_MAX)),
                            vel);
                else
                  send_tick(1'b1, LOAD_W'($urandom), '0);
              end
              1: send_tick(1'b1, LOAD_W'($urandom_range(0, tracker.regs.stall_threshold)),
                           VW'(($urandom_range(0, 1) == 1) ? -mag : mag));
              2: send_tick(1'b1, LOAD_W'($urandom), '0);
              default: send_tick(1'b1, LOAD_W'($urandom), vel);
            endcase
          end else begin
            send_tick(1'($urandom), LOAD_W'($urandom), vel);
          end
        end
        repeat ($urandom_range(1, 3)) send_tick(1'b0, LOAD_W'($urandom), VW'($urandom));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_ch.valid          = 1'b0;
    in_ch.homing_request = 1'b0;
    in_ch.motor_load     = '0;
    in_ch.velocity       = '0;
    out_ch.ready         = 1'b0;
    send_idle_pct        = 33;
    recv_idle_pct        = 60;
    ticks_sent           = 0;
    settings             = 1;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed walk under the reset registers: every threshold and debounce
    // is zero, so only a zero load stalls, any motion is fast enough and each
    // phase needs two qualifying ticks.
    send_tick(1'b0, '0, 1);              // no request: stays unknown
    send_tick(1'b1, '0, 1);              // enters searching, counter to one
    send_tick(1'b1, '0, -1);             // advances to backing, switch on
    send_tick(1'b1, LOAD_MAX, '0);       // backing without motion clears
    send_tick(1'b1, LOAD_MAX, -1);       // backing counts on motion alone
    send_tick(1'b1, LOAD_MAX, VEL_MIN);  // to latching, switch off
    send_tick(1'b1, 10'd1, 5);           // load just above threshold clears
    send_tick(1'b1, '0, '0);             // stalled but not moving clears
    send_tick(1'b1, '0, VEL_MAX);
    send_tick(1'b1, '0, VEL_MIN);        // reaches homed, switch on
    send_tick(1'b1, '0, 7);              // homed holds with the request
    send_tick(1'b1, LOAD_MAX, '0);
    send_tick(1'b0, LOAD_MAX, VEL_MIN);  // request dropped: all cleared
    wait_drained();

    // Thresholds at full scale: every load stalls, but only the most negative
    // velocity is faster than the speed threshold.
    program_regs(int'(LOAD_MAX), (1 << SPEED_W) - 1, 0, 0, 0);
    send_tick(1'b1, LOAD_MAX, VEL_MAX);  // magnitude equals threshold: not fast
    send_tick(1'b1, LOAD_MAX, VEL_MIN);
    send_tick(1'b1, LOAD_MAX, VEL_MIN);  // to backing
    send_tick(1'b1, '0, 1);
    send_tick(1'b1, '0, 1);              // to latching
    send_tick(1'b1, 10'd512, VEL_MIN);
    send_tick(1'b0, 10'd512, VEL_MIN);   // request lost halfway through latching
    wait_drained();

    // Six register settings, some randomized; the idling pattern changes every two of them.
    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        send_idle_pct = 33;
        recv_idle_pct = 60;
      end else if (p < 4) begin
        send_idle_pct = 60;
        recv_idle_pct = 33;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (p)
        0: program_regs(512, 1000, 1, 2, 1);
        1: program_regs($urandom_range(100, 900), $urandom_range(0, 1 << 22),
                        $urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4));
        2: program_regs(0, 0, 0, 0, 0);
        3: program_regs(int'(LOAD_MAX), (1 << SPEED_W) - 1, 0, 1, 0);
        4: program_regs($urandom_range(0, LOAD_MAX), $urandom_range(0, 1 << 20),
                        $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
        default: program_regs($urandom_range(0, LOAD_MAX), $urandom_range(0, 1 << 23),
                              $urandom_range(2, 8), $urandom_range(2, 8),
                              $urandom_range(2, 8));
      endcase
      run_random_phase(300);
      wait_drained();
    end

    // Debounce registers at 65534: a short stall run keeps the machine in
    // searching while the counter climbs.
    program_regs(int'(LOAD_MAX), 0, DEB_MAX, DEB_MAX, DEB_MAX);
    repeat (LONG_RUN) send_stall_tick();
    wait_drained();

    repeat (8) @(posedge clk);
    $display("Checked %0d result words for %0d tick words over %0d register settings.",
             tracker.results, ticks_sent, settings);
    $display("Homed phase seen in %0d result words; closing stall run was %0d ticks.",
             tracker.homed_hits, LONG_RUN);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
